>>> hw/rtl/b64v_pkg.sv
// ----------------------------------------------------------------------------
// b64v_pkg
// Types and the character table shared by the base64 variant stream encoder.
// ----------------------------------------------------------------------------
package b64v_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [5:0] code_t;
    typedef logic [6:0] char_t;
    typedef logic [1:0] phase_t;
    typedef logic [3:0] carry_t;

    localparam phase_t PH_FIRST  = 2'd0;
    localparam phase_t PH_SECOND = 2'd1;
    localparam phase_t PH_THIRD  = 2'd2;

    // alphabet A-Z a-z 0-9 _ $
    function automatic char_t code_to_char(input code_t code);
        char_t c;
        c = 7'h00;
        case (code) inside
            [6'd0:6'd25]:  c = 7'h41 + 7'(code);
            [6'd26:6'd51]: c = 7'h61 + 7'(code - 6'd26);
            [6'd52:6'd61]: c = 7'h30 + 7'(code - 6'd52);
            6'd62:         c = 7'h5F;
            default:       c = 7'h24;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/base64_variant_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_variant_stream_encoder
// Byte stream to base64 variant characters (alphabet ends in '_' and '$').
// ----------------------------------------------------------------------------
// Bytes come in on the slave side, tlast marking the final byte of a message.
// Each group of three bytes is packed least significant byte first and cut
// into 6-bit codes from bit 0 up; a character leaves as soon as its bits are
// known, so a byte gives one character, or two on the third byte of a group
// and on the last byte of a message. There is no '=' padding: a final group
// of one byte gives two characters, one of two bytes gives three. The last
// character of a message carries tlast. A byte is encoded combinationally into a
// two-character output register; a byte that gives one character can be taken
// every cycle while the master side accepts, one that gives two holds the port
// while both characters drain through the single master-side word per cycle.
module base64_variant_stream_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,     // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [6:0] code_char, [7] zero
    output logic       m_tlast      // last_char
);
    import b64v_pkg::*;

    phase_t     phase_reg, phase_next;
    carry_t     carry_reg, carry_next;
    logic [1:0] count_reg, count_next;
    char_t      char0_reg, char0_next;
    char_t      char1_reg, char1_next;
    logic       last0_reg, last0_next;
    logic       last1_reg, last1_next;

    logic       push, pop;
    code_t      code0, code1;
    logic       two_chars;
    logic       last_first;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {1'b0, char0_reg};
    assign m_tlast  = last0_reg;
    assign pop      = m_tvalid && m_tready;
    // room when the register is empty or its only word leaves this cycle
    assign s_tready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        code0      = s_tdata[5:0];
        code1      = {4'd0, s_tdata[7:6]};
        two_chars  = s_tlast;
        last_first = 1'b0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        case (phase_reg)
            PH_SECOND:
            begin
                code0      = {s_tdata[3:0], carry_reg[1:0]};
                code1      = {2'd0, s_tdata[7:4]};
                carry_next = s_tdata[7:4];
                phase_next = PH_THIRD;
            end
            PH_THIRD:
            begin
                code0      = {s_tdata[1:0], carry_reg};
                code1      = s_tdata[7:2];
                two_chars  = 1'b1;
                carry_next = 4'd0;
                phase_next = PH_FIRST;
            end
            default:
            begin
                carry_next = {2'd0, s_tdata[7:6]};
                phase_next = PH_SECOND;
            end
        endcase
        if (s_tlast)
        begin
            phase_next = PH_FIRST;
            carry_next = 4'd0;
        end
        if (!push)
        begin
            phase_next = phase_reg;
            carry_next = carry_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        char0_next = char0_reg;
        char1_next = char1_reg;
        last0_next = last0_reg;
        last1_next = last1_reg;
        if (pop)
        begin
            count_next = count_reg - 2'd1;
            char0_next = char1_reg;
            last0_next = last1_reg;
        end
        if (push)
        begin
            count_next = two_chars ? 2'd2 : 2'd1;
            char0_next = code_to_char(code0);
            char1_next = code_to_char(code1);
            last0_next = s_tlast && !two_chars;
            last1_next = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            carry_reg <= 4'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char0_reg <= char0_next;
        char1_reg <= char1_next;
        last0_reg <= last0_next;
        last1_reg <= last1_next;
    end

    // at most two words ever held
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("output register overfilled");

    // a byte is only taken when the register is empty by the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg == 2'd0) || pop)
        else $error("byte accepted over a pending word");

    // a message end restarts the group
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && s_tlast) |=> (phase_reg == PH_FIRST) && (carry_reg == 4'd0))
        else $error("group not restarted after message end");

    // two words always drain to one
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && m_tready) |=> count_reg == 2'd1)
        else $error("second word lost or repeated");

    // phase three byte never leaves carried bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && phase_reg == PH_THIRD) |=> carry_reg == 4'd0)
        else $error("carry left after full group");

endmodule
